// File: hw/rtl/mtt_pkg.sv
// Shared types and constants for the multiplexed timer table.
// Used by multiplexed_timer_table; depends on nothing.
package mtt_pkg;

   localparam int REM_W = 31;
   localparam int EV_W  = 8;
   localparam int ENTRY_W = REM_W + EV_W;

   localparam logic [1:0] OP_DECLARE = 2'd0;
   localparam logic [1:0] OP_CANCEL  = 2'd1;
   localparam logic [1:0] OP_ALARM   = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam logic [2:0] KIND_FIRED     = 3'd0;
   localparam logic [2:0] KIND_DECLARED  = 3'd1;
   localparam logic [2:0] KIND_FULL      = 3'd2;
   localparam logic [2:0] KIND_CANCELLED = 3'd3;
   localparam logic [2:0] KIND_NOT_ACT   = 3'd4;
   localparam logic [2:0] KIND_ALARM     = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DECL_CMP,
      ST_SCAN,
      ST_FINAL
   } state_type;

endpackage

// File: hw/rtl/mtt_slot_ram.sv
// Slot memory of the timer table: one write port, one read port with
// registered read data. Depends on nothing.
module mtt_slot_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 39
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/multiplexed_timer_table.sv
// Multiplexed timer table: a table of software timer slots sharing one countdown.
// A fresh declare, a cancel without ageing or a rejected item goes from dispatch
// straight to its last word; a declare compared against the next timer passes the
// compare state first. Items that age scan every slot, one slot entry per cycle.
// Items are worked one at a time; a result word stalled at the output stalls the scan.
// Reset is synchronous; it frees every slot at once, so no clearing pass follows.
module multiplexed_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [30:0] req_delay,
   input  logic [7:0]  req_event_id,
   input  logic [3:0]  req_slot,
   input  logic [30:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot_res,
   output logic [7:0]  rsp_event_id_res,
   output logic        rsp_reload_valid,
   output logic [30:0] rsp_reload_time,
   output logic        rsp_last
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   mtt_pkg::state_type state_ff, state_in;

   // Latched request word.
   logic [1:0]  op_ff, op_in;
   logic [30:0] delay_ff, delay_in;
   logic [7:0]  event_ff, event_in;
   logic [3:0]  slot_ff, slot_in;
   logic [30:0] now_ff, now_in;
   logic [30:0] elapsed_ff, elapsed_in;

   // Table control state.
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic                 next_valid_ff, next_valid_in;
   logic [SW-1:0]        next_slot_ff, next_slot_in;
   logic [30:0]          set_time_ff, set_time_in;

   // Scan state and the earliest survivor seen so far.
   logic [SW-1:0] ptr_ff, ptr_in;
   logic          best_found_ff, best_found_in;
   logic [SW-1:0] best_slot_ff, best_slot_in;
   logic [30:0]   best_rem_ff, best_rem_in;

   // What the final word of the item reports and commits.
   logic [SW-1:0] free_slot_ff, free_slot_in;
   logic [2:0]    fin_kind_ff, fin_kind_in;
   logic [3:0]    fin_slot_ff, fin_slot_in;
   logic          decl_ok_ff, decl_ok_in;
   logic          decl_reload_ff, decl_reload_in;
   logic          aged_ff, aged_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [7:0]  rsp_ev_ff, rsp_ev_in;
   logic        rsp_rv_ff, rsp_rv_in;
   logic [30:0] rsp_rt_ff, rsp_rt_in;
   logic        rsp_last_ff, rsp_last_in;

   // Memory port.
   logic                          wr_en;
   logic [SW-1:0]                 wr_addr, rd_addr;
   logic [mtt_pkg::ENTRY_W-1:0]   wr_data, rd_data;
   logic [30:0]                   q_rem, aged_rem;
   logic [7:0]                    q_ev;

   logic          out_free;
   logic          has_free;
   logic [SW-1:0] free_idx;
   logic [SW-1:0] sl_idx;
   logic          cancel_ok;
   logic          cancel_next;
   logic          due_earlier;
   logic          survives;
   logic          scan_adv;

   mtt_slot_ram #(
      .DEPTH (NUM_SLOTS),
      .AW    (SW),
      .DW    (mtt_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_rem    = rd_data[mtt_pkg::REM_W-1:0];
   assign q_ev     = rd_data[mtt_pkg::ENTRY_W-1:mtt_pkg::REM_W];
   assign aged_rem = q_rem - elapsed_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Lowest free slot; searched from the top so the lowest index wins.
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            has_free = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign sl_idx      = SW'(slot_ff);
   assign cancel_ok   = (32'(slot_ff) < 32'(NUM_SLOTS)) && active_ff[sl_idx];
   assign cancel_next = next_valid_ff && (next_slot_ff == sl_idx);

   // The new timer is due earlier when its absolute expiry, taken without wrap,
   // lies before that of the current next timer.
   assign due_earlier = ({1'b0, delay_ff} + {1'b0, now_ff}) <
                        ({1'b0, q_rem} + {1'b0, set_time_ff});

   // A scanned entry either survives with less time, is free, or fires and
   // then needs the output register.
   assign survives = q_rem > elapsed_ff;
   assign scan_adv = !active_ff[ptr_ff] || survives || out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtt_pkg::ST_IDLE: begin
            if (req_valid && (req_opcode == mtt_pkg::OP_DECLARE ||
                              req_opcode == mtt_pkg::OP_CANCEL ||
                              req_opcode == mtt_pkg::OP_ALARM)) begin
               state_in = mtt_pkg::ST_DISPATCH;
            end
         end
         mtt_pkg::ST_DISPATCH: begin
            case (op_ff)
               mtt_pkg::OP_DECLARE: begin
                  state_in = (has_free && next_valid_ff) ? mtt_pkg::ST_DECL_CMP
                                                         : mtt_pkg::ST_FINAL;
               end
               mtt_pkg::OP_CANCEL: begin
                  state_in = (cancel_ok && cancel_next) ? mtt_pkg::ST_SCAN
                                                        : mtt_pkg::ST_FINAL;
               end
               default: state_in = mtt_pkg::ST_SCAN;
            endcase
         end
         mtt_pkg::ST_DECL_CMP: begin
            state_in = due_earlier ? mtt_pkg::ST_SCAN : mtt_pkg::ST_FINAL;
         end
         mtt_pkg::ST_SCAN: begin
            if (scan_adv && ptr_ff == LAST_SLOT) begin
               state_in = mtt_pkg::ST_FINAL;
            end
         end
         mtt_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = mtt_pkg::ST_IDLE;
            end
         end
         default: state_in = mtt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs of each state.
   always_comb begin
      op_in          = op_ff;
      delay_in       = delay_ff;
      event_in       = event_ff;
      slot_in        = slot_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      active_in      = active_ff;
      next_valid_in  = next_valid_ff;
      next_slot_in   = next_slot_ff;
      set_time_in    = set_time_ff;
      ptr_in         = ptr_ff;
      best_found_in  = best_found_ff;
      best_slot_in   = best_slot_ff;
      best_rem_in    = best_rem_ff;
      free_slot_in   = free_slot_ff;
      fin_kind_in    = fin_kind_ff;
      fin_slot_in    = fin_slot_ff;
      decl_ok_in     = decl_ok_ff;
      decl_reload_in = decl_reload_ff;
      aged_in        = aged_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_rv_in      = rsp_rv_ff;
      rsp_rt_in      = rsp_rt_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff;
      wr_data        = {q_ev, aged_rem};
      rd_addr        = ptr_ff;

      unique case (state_ff)
         mtt_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in          = req_opcode;
               delay_in       = req_delay;
               event_in       = req_event_id;
               slot_in        = req_slot;
               now_in         = req_now;
               elapsed_in     = req_now - set_time_ff;
               aged_in        = 1'b0;
               decl_ok_in     = 1'b0;
               decl_reload_in = 1'b0;
               best_found_in  = 1'b0;
               best_slot_in   = '0;
               best_rem_in    = '0;
            end
         end
         mtt_pkg::ST_DISPATCH: begin
            case (op_ff)
               mtt_pkg::OP_DECLARE: begin
                  if (!has_free) begin
                     fin_kind_in = mtt_pkg::KIND_FULL;
                     fin_slot_in = '0;
                  end else begin
                     // The new entry is written now but stays inactive
                     // until the final word, so ageing never touches it.
                     wr_en        = 1'b1;
                     wr_addr      = free_idx;
                     wr_data      = {event_ff, delay_ff};
                     free_slot_in = free_idx;
                     decl_ok_in   = 1'b1;
                     fin_kind_in  = mtt_pkg::KIND_DECLARED;
                     fin_slot_in  = 4'(free_idx);
                     if (!next_valid_ff) begin
                        decl_reload_in = 1'b1;
                     end else begin
                        rd_addr = next_slot_ff;
                     end
                  end
               end
               mtt_pkg::OP_CANCEL: begin
                  fin_slot_in = slot_ff;
                  if (!cancel_ok) begin
                     fin_kind_in = mtt_pkg::KIND_NOT_ACT;
                  end else begin
                     fin_kind_in       = mtt_pkg::KIND_CANCELLED;
                     active_in[sl_idx] = 1'b0;
                     if (cancel_next) begin
                        rd_addr = '0;
                        ptr_in  = '0;
                        aged_in = 1'b1;
                     end
                  end
               end
               default: begin
                  fin_kind_in = mtt_pkg::KIND_ALARM;
                  fin_slot_in = '0;
                  rd_addr     = '0;
                  ptr_in      = '0;
                  aged_in     = 1'b1;
               end
            endcase
         end
         mtt_pkg::ST_DECL_CMP: begin
            if (due_earlier) begin
               decl_reload_in = 1'b1;
               aged_in        = 1'b1;
               rd_addr        = '0;
               ptr_in         = '0;
            end
         end
         mtt_pkg::ST_SCAN: begin
            if (scan_adv) begin
               rd_addr = ptr_ff + 1'b1;
               if (ptr_ff != LAST_SLOT) begin
                  ptr_in = ptr_ff + 1'b1;
               end
               if (active_ff[ptr_ff]) begin
                  if (survives) begin
                     wr_en = 1'b1;
                     if (!best_found_ff || aged_rem < best_rem_ff) begin
                        best_found_in = 1'b1;
                        best_slot_in  = ptr_ff;
                        best_rem_in   = aged_rem;
                     end
                  end else begin
                     active_in[ptr_ff] = 1'b0;
                     rsp_valid_in      = 1'b1;
                     rsp_kind_in       = mtt_pkg::KIND_FIRED;
                     rsp_slot_in       = 4'(ptr_ff);
                     rsp_ev_in         = q_ev;
                     rsp_rv_in         = 1'b0;
                     rsp_rt_in         = '0;
                     rsp_last_in       = 1'b0;
                  end
               end
            end
         end
         mtt_pkg::ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fin_kind_ff;
               rsp_slot_in  = fin_slot_ff;
               rsp_ev_in    = '0;
               rsp_rv_in    = 1'b0;
               rsp_rt_in    = '0;
               rsp_last_in  = 1'b1;
               if (aged_ff) begin
                  next_valid_in = best_found_ff;
                  next_slot_in  = best_found_ff ? best_slot_ff : '0;
                  if (best_found_ff) begin
                     set_time_in = now_ff;
                     rsp_rv_in   = 1'b1;
                     rsp_rt_in   = best_rem_ff;
                  end
               end
               if (decl_ok_ff) begin
                  active_in[free_slot_ff] = 1'b1;
                  if (decl_reload_ff) begin
                     next_valid_in = 1'b1;
                     next_slot_in  = free_slot_ff;
                     set_time_in   = now_ff;
                     rsp_rv_in     = 1'b1;
                     rsp_rt_in     = delay_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtt_pkg::ST_IDLE;
         active_ff     <= '0;
         next_valid_ff <= 1'b0;
         next_slot_ff  <= '0;
         set_time_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         next_valid_ff <= next_valid_in;
         next_slot_ff  <= next_slot_in;
         set_time_ff   <= set_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      delay_ff       <= delay_in;
      event_ff       <= event_in;
      slot_ff        <= slot_in;
      now_ff         <= now_in;
      elapsed_ff     <= elapsed_in;
      ptr_ff         <= ptr_in;
      best_found_ff  <= best_found_in;
      best_slot_ff   <= best_slot_in;
      best_rem_ff    <= best_rem_in;
      free_slot_ff   <= free_slot_in;
      fin_kind_ff    <= fin_kind_in;
      fin_slot_ff    <= fin_slot_in;
      decl_ok_ff     <= decl_ok_in;
      decl_reload_ff <= decl_reload_in;
      aged_ff        <= aged_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_rv_ff      <= rsp_rv_in;
      rsp_rt_ff      <= rsp_rt_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ready        = (state_ff == mtt_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_slot_res     = rsp_slot_ff;
   assign rsp_event_id_res = rsp_ev_ff;
   assign rsp_reload_valid = rsp_rv_ff;
   assign rsp_reload_time  = rsp_rt_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // Between items the next timer is always a live slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtt_pkg::ST_IDLE && next_valid_ff) |-> active_ff[next_slot_ff])
      else $error("next timer points at a free slot");

   // Only fired words come before the last word, and they never reload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         (rsp_kind_ff == mtt_pkg::KIND_FIRED && !rsp_rv_ff))
      else $error("non-final word is not a plain fired word");

   // A real opcode always starts the work on the item.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode != mtt_pkg::OP_IGNORED) |=>
         (state_ff == mtt_pkg::ST_DISPATCH))
      else $error("accepted word did not start dispatch");

   // The scan pointer stays inside the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtt_pkg::ST_SCAN) |-> (32'(ptr_ff) < 32'(NUM_SLOTS)))
      else $error("scan pointer out of range");
`endif

endmodule
